/* rtl/core/qrs_pkg.sv */
// qrs_pkg: output field widths and status codes of the quadratic root solver
// no dependencies
`default_nettype none
package qrs_pkg;
  localparam int DISC_W = 34;
  localparam int ROOT_W = 40;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_REAL    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEG     = 2'd1;
  localparam logic [STAT_W-1:0] ST_A_ZERO  = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/quadratic_root_solver_core.sv */
// quadratic_root_solver_core: pipelined discriminant, square root and root division
// depends on qrs_pkg
//
// Takes one coefficient transaction (a, b, c) per cycle and returns the exact
// discriminant, a status and both roots in signed fixed point with FRAC_BITS
// fraction bits. It has SW = COEF_BITS+FRAC_BITS+1 square root stages (one result bit
// each) and NW = COEF_BITS+FRAC_BITS+2 divider stages (one quotient bit each for
// both roots). The whole pipeline advances together and holds while a result
// waits on out_ready, so a new transaction is taken every cycle the output
// is free or being taken.
`default_nettype none
module quadratic_root_solver_core
  import qrs_pkg::*;
#(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [15:0]         in_coef_a,
  input  wire logic [15:0]         in_coef_b,
  input  wire logic [15:0]         in_coef_c,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [DISC_W-1:0]        out_disc_value,
  output logic [STAT_W-1:0]        out_root_status,
  output logic [ROOT_W-1:0]        out_root_plus,
  output logic [ROOT_W-1:0]        out_root_minus
);
  localparam int CB  = COEF_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int PW  = 2 * CB;
  localparam int DW  = 2 * CB + 2;
  localparam int SW  = CB + FB + 1;
  localparam int RW  = 2 * SW;
  localparam int NW  = CB + FB + 2;
  localparam int DVW = CB + 1;
  localparam int XDW = (DW > DISC_W) ? DW : DISC_W;
  localparam int XRW = (NW + 1 > ROOT_W) ? NW + 1 : ROOT_W;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: coefficients
  logic                 v0_r;
  logic signed [CB-1:0] a0_r, b0_r, c0_r;
  // stage 1: products
  logic                 v1_r;
  logic signed [PW-1:0] bb1_r, ac1_r;
  logic signed [CB-1:0] a1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r  <= CB'(in_coef_a);
      b0_r  <= CB'(in_coef_b);
      c0_r  <= CB'(in_coef_c);
      bb1_r <= b0_r * b0_r;
      ac1_r <= a0_r * c0_r;
      a1_r  <= a0_r;
      b1_r  <= b0_r;
    end
  end

  // stage 2: discriminant, status, radicand
  logic signed [DW-1:0]   d_nxt;
  logic signed [XDW:0]    dx;
  logic [DISC_W-1:0]      dsat_nxt;
  logic [STAT_W-1:0]      st_nxt;
  logic [RW-1:0]          rad_nxt;
  logic signed [NW:0]     nb_nxt;
  logic signed [CB+1:0]   a2x;
  logic [DVW-1:0]         dv_nxt;

  always_comb begin
    d_nxt = DW'(bb1_r) - (DW'(ac1_r) <<< 2);
    dx    = (XDW + 1)'(d_nxt);
    if (&dx[XDW:DISC_W-1] || ~|dx[XDW:DISC_W-1]) begin
      dsat_nxt = dx[DISC_W-1:0];
    end else if (dx[XDW]) begin
      dsat_nxt = {1'b1, {(DISC_W-1){1'b0}}};
    end else begin
      dsat_nxt = {1'b0, {(DISC_W-1){1'b1}}};
    end
    if (a1_r == '0) begin
      st_nxt = ST_A_ZERO;
    end else if (d_nxt[DW-1]) begin
      st_nxt = ST_NEG;
    end else begin
      st_nxt = ST_REAL;
    end
    if (st_nxt == ST_REAL) begin
      rad_nxt = RW'(d_nxt[DW-2:0]) << (2 * FB);
    end else begin
      rad_nxt = '0;
    end
    nb_nxt = -((NW + 1)'(b1_r) <<< FB);
    a2x    = (CB + 2)'(a1_r) <<< 1;
    dv_nxt = a2x[CB+1] ? DVW'(-a2x) : DVW'(a2x);
  end

  // square root pipeline, index 0 is stage 2
  logic                 sv_r   [SW+1];
  logic [RW-1:0]        srad_r [SW+1];
  logic [SW+1:0]        srem_r [SW+1];
  logic [SW-1:0]        sroot_r[SW+1];
  logic [DISC_W-1:0]    sdisc_r[SW+1];
  logic [STAT_W-1:0]    sst_r  [SW+1];
  logic signed [NW:0]   snb_r  [SW+1];
  logic [DVW-1:0]       sdv_r  [SW+1];
  logic                 sneg_r [SW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srad_r[0]  <= rad_nxt;
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      sdisc_r[0] <= dsat_nxt;
      sst_r[0]   <= st_nxt;
      snb_r[0]   <= nb_nxt;
      sdv_r[0]   <= dv_nxt;
      sneg_r[0]  <= a1_r[CB-1];
    end
  end

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    logic [SW+1:0] rem_sh;
    logic [SW+1:0] trial;
    logic          take;
    always_comb begin
      rem_sh = {srem_r[i][SW-1:0], srad_r[i][RW-1:RW-2]};
      trial  = {sroot_r[i], 2'b01};
      take   = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i+1] <= 1'b0;
      end else if (en) begin
        sv_r[i+1] <= sv_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        srad_r[i+1]  <= srad_r[i] << 2;
        srem_r[i+1]  <= take ? rem_sh - trial : rem_sh;
        sroot_r[i+1] <= {sroot_r[i][SW-2:0], take};
        sdisc_r[i+1] <= sdisc_r[i];
        sst_r[i+1]   <= sst_r[i];
        snb_r[i+1]   <= snb_r[i];
        sdv_r[i+1]   <= sdv_r[i];
        sneg_r[i+1]  <= sneg_r[i];
      end
    end
  end

  // numerators, index 0 of the divider pipeline
  logic signed [NW:0] np_nxt, nm_nxt;
  always_comb begin
    np_nxt = snb_r[SW] + $signed({1'b0, sroot_r[SW]});
    nm_nxt = snb_r[SW] - $signed({1'b0, sroot_r[SW]});
  end

  logic                 dvld_r [NW+1];
  logic [NW-1:0]        pnum_r [NW+1];
  logic [NW-1:0]        mnum_r [NW+1];
  logic [DVW-1:0]       prem_r [NW+1];
  logic [DVW-1:0]       mrem_r [NW+1];
  logic                 pneg_r [NW+1];
  logic                 mneg_r [NW+1];
  logic [DVW-1:0]       ddv_r  [NW+1];
  logic [DISC_W-1:0]    ddisc_r[NW+1];
  logic [STAT_W-1:0]    dst_r  [NW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r[0] <= 1'b0;
    end else if (en) begin
      dvld_r[0] <= sv_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pnum_r[0]  <= np_nxt[NW] ? NW'(-np_nxt) : NW'(np_nxt);
      mnum_r[0]  <= nm_nxt[NW] ? NW'(-nm_nxt) : NW'(nm_nxt);
      prem_r[0]  <= '0;
      mrem_r[0]  <= '0;
      pneg_r[0]  <= np_nxt[NW] ^ sneg_r[SW];
      mneg_r[0]  <= nm_nxt[NW] ^ sneg_r[SW];
      ddv_r[0]   <= sdv_r[SW];
      ddisc_r[0] <= sdisc_r[SW];
      dst_r[0]   <= sst_r[SW];
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DVW:0] prs, mrs;
    logic         pq, mq;
    always_comb begin
      prs = {prem_r[j], pnum_r[j][NW-1]};
      mrs = {mrem_r[j], mnum_r[j][NW-1]};
      pq  = prs >= {1'b0, ddv_r[j]};
      mq  = mrs >= {1'b0, ddv_r[j]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[j+1] <= 1'b0;
      end else if (en) begin
        dvld_r[j+1] <= dvld_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        prem_r[j+1]  <= pq ? DVW'(prs - {1'b0, ddv_r[j]}) : DVW'(prs);
        mrem_r[j+1]  <= mq ? DVW'(mrs - {1'b0, ddv_r[j]}) : DVW'(mrs);
        pnum_r[j+1]  <= {pnum_r[j][NW-2:0], pq};
        mnum_r[j+1]  <= {mnum_r[j][NW-2:0], mq};
        pneg_r[j+1]  <= pneg_r[j];
        mneg_r[j+1]  <= mneg_r[j];
        ddv_r[j+1]   <= ddv_r[j];
        ddisc_r[j+1] <= ddisc_r[j];
        dst_r[j+1]   <= dst_r[j];
      end
    end
  end

  // output stage: sign, saturation, zero for non-real cases
  logic signed [NW:0]    pq_s, mq_s;
  logic signed [XRW-1:0] px, mx;
  logic [ROOT_W-1:0]     prt_nxt, mrt_nxt;

  always_comb begin
    pq_s = pneg_r[NW] ? -$signed({1'b0, pnum_r[NW]}) : $signed({1'b0, pnum_r[NW]});
    mq_s = mneg_r[NW] ? -$signed({1'b0, mnum_r[NW]}) : $signed({1'b0, mnum_r[NW]});
    px   = XRW'(pq_s);
    mx   = XRW'(mq_s);
    if (&px[XRW-1:ROOT_W-1] || ~|px[XRW-1:ROOT_W-1]) begin
      prt_nxt = px[ROOT_W-1:0];
    end else begin
      prt_nxt = px[XRW-1] ? {1'b1, {(ROOT_W-1){1'b0}}} : {1'b0, {(ROOT_W-1){1'b1}}};
    end
    if (&mx[XRW-1:ROOT_W-1] || ~|mx[XRW-1:ROOT_W-1]) begin
      mrt_nxt = mx[ROOT_W-1:0];
    end else begin
      mrt_nxt = mx[XRW-1] ? {1'b1, {(ROOT_W-1){1'b0}}} : {1'b0, {(ROOT_W-1){1'b1}}};
    end
    if (dst_r[NW] != ST_REAL) begin
      prt_nxt = '0;
      mrt_nxt = '0;
    end
  end

  logic                 out_valid_r;
  logic [DISC_W-1:0]    disc_r;
  logic [STAT_W-1:0]    status_r;
  logic [ROOT_W-1:0]    plus_r, minus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dvld_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc_r   <= ddisc_r[NW];
      status_r <= dst_r[NW];
      plus_r   <= prt_nxt;
      minus_r  <= mrt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_disc_value  = disc_r;
  assign out_root_status = status_r;
  assign out_root_plus   = plus_r;
  assign out_root_minus  = minus_r;
endmodule
`default_nettype wire

/* tb/testbench.sv */
// testbench: random and directed coefficient transactions for quadratic_root_solver_core
// depends on qrs_pkg and the solver core; predicts results with its own fixed point math
`default_nettype none
module testbench;
  import qrs_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } coef_t;

  typedef struct packed {
    logic [DISC_W-1:0] disc;
    logic [STAT_W-1:0] status;
    logic [ROOT_W-1:0] rp;
    logic [ROOT_W-1:0] rm;
  } roots_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_coef_a = '0;
  logic [15:0] in_coef_b = '0;
  logic [15:0] in_coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DISC_W-1:0] out_disc_value;
  logic [STAT_W-1:0] out_root_status;
  logic [ROOT_W-1:0] out_root_plus;
  logic [ROOT_W-1:0] out_root_minus;

  coef_t pending_coefs[$];
  roots_t expected_roots[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int cycle_no = 0;
  int hold_off = 0;
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;

  quadratic_root_solver_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_disc_value(out_disc_value), .out_root_status(out_root_status),
    .out_root_plus(out_root_plus), .out_root_minus(out_root_minus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned isqrt_frac(longint unsigned d);
    logic [127:0] rad;
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] trial;
    rad = 128'(d) << (2 * FRAC);
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic roots_t solve_roots(coef_t x);
    longint a;
    longint b;
    longint c;
    longint d;
    longint s;
    longint nb;
    roots_t r;
    a = longint'($signed(x.a));
    b = longint'($signed(x.b));
    c = longint'($signed(x.c));
    d = b * b - 4 * a * c;
    r.disc = d[DISC_W-1:0];
    r.rp = '0;
    r.rm = '0;
    if (a == 0) begin
      r.status = ST_A_ZERO;
    end else if (d < 0) begin
      r.status = ST_NEG;
    end else begin
      s = longint'(isqrt_frac(d));
      nb = -b * (longint'(1) << FRAC);
      r.status = ST_REAL;
      r.rp = 40'((nb + s) / (2 * a));
      r.rm = 40'((nb - s) / (2 * a));
    end
    return r;
  endfunction

  always @(negedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_coefs.size() > 0 &&
            (cycle_no % 1000 > 700 || $urandom_range(99) >= 25)) begin
          in_valid <= 1'b1;
          {in_coef_a, in_coef_b, in_coef_c} <= pending_coefs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (rst_n && cycle_no == 400) begin
      hold_off <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && (cycle_no % 1000 > 700 || $urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    roots_t got;
    roots_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_roots.push_back(solve_roots({in_coef_a, in_coef_b, in_coef_c}));
      if (out_valid && out_ready) begin
        got = {out_disc_value, out_root_status, out_root_plus, out_root_minus};
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %h", got);
        end else begin
          want = expected_roots.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch disc %h/%h status %0d/%0d plus %h/%h minus %h/%h",
                       want.disc, got.disc, want.status, got.status,
                       want.rp, got.rp, want.rm, got.rm);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    coef_t x;
    pending_coefs.push_back({16'h0000, 16'h0000, 16'h0000});
    pending_coefs.push_back({16'h0000, 16'h8000, 16'h7fff});
    pending_coefs.push_back({16'h0001, 16'hfffd, 16'h0002});
    pending_coefs.push_back({16'h0001, 16'h0000, 16'h0001});
    pending_coefs.push_back({16'h0001, 16'h0002, 16'h0001});
    pending_coefs.push_back({16'h8000, 16'h8000, 16'h7fff});
    pending_coefs.push_back({16'h7fff, 16'h8000, 16'h8000});
    pending_coefs.push_back({16'h8000, 16'h7fff, 16'h8000});
    pending_coefs.push_back({16'h7fff, 16'h7fff, 16'h7fff});
    pending_coefs.push_back({16'hffff, 16'h0001, 16'h0000});
    pending_coefs.push_back({16'hffff, 16'hffff, 16'hffff});
    pending_coefs.push_back({16'h0002, 16'h0000, 16'hfffe});
    pending_coefs.push_back({16'h0001, 16'h0000, 16'h0000});
    for (int i = 0; i < 550; i++) begin
      x.a = pick_coef();
      x.b = pick_coef();
      x.c = pick_coef();
      if ($urandom_range(9) == 0) x.a = 16'h0000;
      pending_coefs.push_back(x);
    end
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_coefs.size() == 0 && !in_valid);
    wait (expected_roots.size() == 0);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
rtl/core/qrs_pkg.sv
rtl/core/quadratic_root_solver_core.sv
tb/testbench.sv
